### sv/blca_pkg.sv
// Shared constants, codes and helper function of the binary lifting LCA unit.
package blca_pkg;

    localparam int NODES   = 1024;
    localparam int LEVELS  = 11;
    localparam int NODE_W  = $clog2(NODES);
    localparam int LVL_W   = $clog2(LEVELS);
    localparam int DEPTH_W = NODE_W;
    localparam int CMP_W   = ((DEPTH_W > LEVELS) ? DEPTH_W : LEVELS) + 1;

    // item function codes
    localparam logic FUNC_ATTACH = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // floor(log2 v) capped at the top jump level; zero for a zero input
    function automatic logic [LVL_W-1:0] top_level(input logic [DEPTH_W-1:0] v);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int k = 0; k < DEPTH_W; k++) begin
            if (v[k]) begin
                r = (k > LEVELS - 1) ? LVL_W'(LEVELS - 1) : LVL_W'(k);
            end
        end
        return r;
    endfunction

endpackage

### sv/binary_lifting_lca_unit.sv
// Binary lifting lowest common ancestor unit: sequencer, depth and jump memories.
// Attach: store depth and first ancestor, then fill each further jump level up to the top
// level of the new depth; node 0 is not attached. Query: two depth reads, LEVELS lift steps
// (a jump adds a row and a depth read), then load a match, or LEVELS common steps and a parent read.
// One item at a time; a held result stalls the last step; one memory read per step sets the pace.
// After reset a clearing pass zeroes both memories node by node, with in_stall high.
module binary_lifting_lca_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [blca_pkg::NODE_W-1:0]    node,
    input  logic [blca_pkg::NODE_W-1:0]    peer,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [blca_pkg::NODE_W-1:0]    ancestor
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_AT_DEP,
        S_AT_ISS,
        S_AT_FILL,
        S_Q_DA,
        S_Q_DB,
        S_LF_CHK,
        S_LF_JMP,
        S_LF_DEP,
        S_CA_CHK,
        S_CA_CMP,
        S_CA_DEP,
        S_FIN_RD,
        S_FIN_LD,
        S_FIN_OUT
    } state_t;

    typedef logic [blca_pkg::LEVELS-1:0][blca_pkg::NODE_W-1:0] jrow_t;

    // memories
    logic [blca_pkg::DEPTH_W-1:0] depth_mem [blca_pkg::NODES];
    jrow_t                        jump_mem  [blca_pkg::NODES];

    // sequencer registers
    state_t                       state_reg, state_next;
    logic [blca_pkg::NODE_W-1:0]  a_reg, a_next;
    logic [blca_pkg::NODE_W-1:0]  b_reg, b_next;
    logic [blca_pkg::DEPTH_W-1:0] da_reg, da_next;
    logic [blca_pkg::DEPTH_W-1:0] db_reg, db_next;
    logic [blca_pkg::LVL_W-1:0]   lvl_reg, lvl_next;
    logic [blca_pkg::NODE_W-1:0]  res_reg, res_next;
    logic [blca_pkg::NODE_W-1:0]  clr_reg, clr_next;
    logic                         out_valid_reg, out_valid_next;
    logic [blca_pkg::NODE_W-1:0]  ancestor_reg, ancestor_next;

    // memory read data
    logic [blca_pkg::DEPTH_W-1:0] dep_rd_reg;
    jrow_t                        jrow_a_reg;
    jrow_t                        jrow_b_reg;

    // memory port controls
    logic [blca_pkg::NODE_W-1:0]  dep_raddr;
    logic                         dep_we;
    logic [blca_pkg::NODE_W-1:0]  dep_waddr;
    logic [blca_pkg::DEPTH_W-1:0] dep_wdata;
    logic [blca_pkg::NODE_W-1:0]  jmp_raddr_a;
    logic [blca_pkg::NODE_W-1:0]  jmp_raddr_b;
    logic                         jmp_we;
    logic                         jmp_clr;
    logic [blca_pkg::NODE_W-1:0]  jmp_waddr;
    logic [blca_pkg::LVL_W-1:0]   jmp_wlvl;
    logic [blca_pkg::NODE_W-1:0]  jmp_wdata;

    // shared arithmetic
    logic [blca_pkg::DEPTH_W:0]   dep_sum;
    logic [blca_pkg::DEPTH_W-1:0] new_depth;
    logic                         lift_ok;
    logic [blca_pkg::NODE_W-1:0]  ja;
    logic [blca_pkg::NODE_W-1:0]  jb;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign ancestor  = ancestor_reg;

    // child depth: parent depth plus one, saturated
    assign dep_sum   = {1'b0, dep_rd_reg} + (blca_pkg::DEPTH_W + 1)'(1);
    assign new_depth = (dep_sum > (blca_pkg::DEPTH_W + 1)'(blca_pkg::NODES - 1))
                     ? blca_pkg::DEPTH_W'(blca_pkg::NODES - 1)
                     : dep_sum[blca_pkg::DEPTH_W-1:0];

    // lift the deeper node while depth(a) - 2^lvl >= depth(b)
    assign lift_ok = blca_pkg::CMP_W'(da_reg) >=
                     ((blca_pkg::CMP_W'(1) << lvl_reg) + blca_pkg::CMP_W'(db_reg));

    assign ja = jrow_a_reg[lvl_reg];
    assign jb = jrow_b_reg[lvl_reg];

    // sequencer next state and memory controls
    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        da_next        = da_reg;
        db_next        = db_reg;
        lvl_next       = lvl_reg;
        res_next       = res_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg & out_stall;
        ancestor_next  = ancestor_reg;
        dep_raddr      = a_reg;
        dep_we         = 1'b0;
        dep_waddr      = a_reg;
        dep_wdata      = '0;
        jmp_raddr_a    = a_reg;
        jmp_raddr_b    = b_reg;
        jmp_we         = 1'b0;
        jmp_clr        = 1'b0;
        jmp_waddr      = a_reg;
        jmp_wlvl       = '0;
        jmp_wdata      = b_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                dep_we    = 1'b1;
                dep_waddr = clr_reg;
                jmp_clr   = 1'b1;
                jmp_waddr = clr_reg;
                clr_next  = clr_reg + blca_pkg::NODE_W'(1);
                if (clr_reg == blca_pkg::NODE_W'(blca_pkg::NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next = node;
                    b_next = peer;
                    if (func == blca_pkg::FUNC_QUERY)
                    begin
                        dep_raddr  = node;
                        state_next = S_Q_DA;
                    end
                    else if (node != '0)
                    begin
                        dep_raddr  = peer;
                        state_next = S_AT_DEP;
                    end
                end
            end
            // store depth and first ancestor
            S_AT_DEP:
            begin
                dep_we    = 1'b1;
                dep_wdata = new_depth;
                jmp_we    = 1'b1;
                jmp_wlvl  = '0;
                jmp_wdata = b_reg;
                da_next   = new_depth;
                lvl_next  = blca_pkg::LVL_W'(1);
                if (blca_pkg::top_level(new_depth) == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_AT_ISS;
                end
            end
            S_AT_ISS:
            begin
                jmp_raddr_a = b_reg;
                state_next  = S_AT_FILL;
            end
            // fill one jump level from the level below
            S_AT_FILL:
            begin
                jmp_we    = 1'b1;
                jmp_wlvl  = lvl_reg;
                jmp_wdata = jrow_a_reg[lvl_reg - blca_pkg::LVL_W'(1)];
                b_next    = jrow_a_reg[lvl_reg - blca_pkg::LVL_W'(1)];
                if (lvl_reg == blca_pkg::top_level(da_reg))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    lvl_next   = lvl_reg + blca_pkg::LVL_W'(1);
                    state_next = S_AT_ISS;
                end
            end
            S_Q_DA:
            begin
                da_next    = dep_rd_reg;
                dep_raddr  = b_reg;
                state_next = S_Q_DB;
            end
            // order the pair so that a is the deeper node
            S_Q_DB:
            begin
                if (da_reg < dep_rd_reg)
                begin
                    a_next  = b_reg;
                    b_next  = a_reg;
                    da_next = dep_rd_reg;
                    db_next = da_reg;
                end
                else
                begin
                    db_next = dep_rd_reg;
                end
                lvl_next   = blca_pkg::LVL_W'(blca_pkg::LEVELS - 1);
                state_next = S_LF_CHK;
            end
            S_LF_CHK:
            begin
                if (lift_ok)
                begin
                    jmp_raddr_a = a_reg;
                    state_next  = S_LF_JMP;
                end
                else if (lvl_reg != '0)
                begin
                    lvl_next = lvl_reg - blca_pkg::LVL_W'(1);
                end
                else if (a_reg == b_reg)
                begin
                    res_next   = a_reg;
                    state_next = S_FIN_OUT;
                end
                else
                begin
                    lvl_next   = blca_pkg::LVL_W'(blca_pkg::LEVELS - 1);
                    state_next = S_CA_CHK;
                end
            end
            S_LF_JMP:
            begin
                a_next     = ja;
                dep_raddr  = ja;
                state_next = S_LF_DEP;
            end
            S_LF_DEP:
            begin
                da_next = dep_rd_reg;
                if (lvl_reg != '0)
                begin
                    lvl_next   = lvl_reg - blca_pkg::LVL_W'(1);
                    state_next = S_LF_CHK;
                end
                else if (a_reg == b_reg)
                begin
                    res_next   = a_reg;
                    state_next = S_FIN_OUT;
                end
                else
                begin
                    lvl_next   = blca_pkg::LVL_W'(blca_pkg::LEVELS - 1);
                    state_next = S_CA_CHK;
                end
            end
            // lift both nodes while their ancestors differ
            S_CA_CHK:
            begin
                if (da_reg != '0 && lvl_reg <= blca_pkg::top_level(da_reg))
                begin
                    jmp_raddr_a = a_reg;
                    jmp_raddr_b = b_reg;
                    state_next  = S_CA_CMP;
                end
                else if (lvl_reg != '0)
                begin
                    lvl_next = lvl_reg - blca_pkg::LVL_W'(1);
                end
                else
                begin
                    state_next = S_FIN_RD;
                end
            end
            S_CA_CMP:
            begin
                if (ja != jb)
                begin
                    a_next     = ja;
                    b_next     = jb;
                    dep_raddr  = ja;
                    state_next = S_CA_DEP;
                end
                else if (lvl_reg != '0)
                begin
                    lvl_next   = lvl_reg - blca_pkg::LVL_W'(1);
                    state_next = S_CA_CHK;
                end
                else
                begin
                    state_next = S_FIN_RD;
                end
            end
            S_CA_DEP:
            begin
                da_next = dep_rd_reg;
                if (lvl_reg != '0)
                begin
                    lvl_next   = lvl_reg - blca_pkg::LVL_W'(1);
                    state_next = S_CA_CHK;
                end
                else
                begin
                    state_next = S_FIN_RD;
                end
            end
            S_FIN_RD:
            begin
                jmp_raddr_a = a_reg;
                state_next  = S_FIN_LD;
            end
            S_FIN_LD:
            begin
                res_next   = jrow_a_reg[0];
                state_next = S_FIN_OUT;
            end
            // hand the result to the output register once it is free
            S_FIN_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ancestor_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            a_reg         <= '0;
            b_reg         <= '0;
            da_reg        <= '0;
            db_reg        <= '0;
            lvl_reg       <= '0;
            res_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            ancestor_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            da_reg        <= da_next;
            db_reg        <= db_next;
            lvl_reg       <= lvl_next;
            res_reg       <= res_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            ancestor_reg  <= ancestor_next;
        end
    end

    // depth memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            depth_mem[dep_waddr] <= dep_wdata;
        end
        dep_rd_reg <= depth_mem[dep_raddr];
    end

    // jump memory: one row per node, per-level write lanes, two registered reads
    always_ff @(posedge clk)
    begin
        if (jmp_clr)
        begin
            jump_mem[jmp_waddr] <= '0;
        end
        else if (jmp_we)
        begin
            jump_mem[jmp_waddr][jmp_wlvl] <= jmp_wdata;
        end
        jrow_a_reg <= jump_mem[jmp_raddr_a];
        jrow_b_reg <= jump_mem[jmp_raddr_b];
    end

endmodule

### sv/blca_checker.sv
// Port-level checks of the binary lifting LCA unit and their binding.
module blca_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           func,
    input  logic [blca_pkg::NODE_W-1:0]    node,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [blca_pkg::NODE_W-1:0]    ancestor
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ancestor))
        else $error("stalled result changed or dropped");

    // a query keeps the unit busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func == blca_pkg::FUNC_QUERY |=> in_stall)
        else $error("unit idle straight after a query item");

    // an attach of a real node keeps the unit busy
    a_attach_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func == blca_pkg::FUNC_ATTACH && node != '0 |=> in_stall)
        else $error("unit idle straight after an attach item");

    // a new result only comes out of a busy sequencer
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work in progress");

    // clearing pass holds off items after reset
    a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_stall)
        else $error("items accepted before the memories were cleared");

endmodule

bind binary_lifting_lca_unit blca_checker u_blca_checker (.*);
